// ===== sv/irw_pkg.sv =====
// Shared constants and types for the image rotation inverse warp unit.
`timescale 1ns / 1ps
`default_nettype none

package irw_pkg;

    // Default sizes of the source frame store and the coordinate fraction
    localparam int SRC_MAX_WIDTH_DEF  = 256;
    localparam int SRC_MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF      = 14;

    // Fixed field widths
    localparam int COORD_W    = 9;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int DIM_W      = 9;
    localparam int ODIM_W     = 10;
    localparam int TRIG_W     = 16;
    localparam int DXY_W      = ODIM_W + 1;
    localparam int PROD_W     = DXY_W + TRIG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WT_W       = 9;
    localparam int WPROD_W    = 17;
    localparam int CPROD_W    = CH_W + WPROD_W;
    localparam int ACC_W      = CPROD_W + 2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS    = 3'd0,
        REG_SIN    = 3'd1,
        REG_SRC_W  = 3'd2,
        REG_SRC_H  = 3'd3,
        REG_OUT_W  = 3'd4,
        REG_OUT_H  = 3'd5,
        REG_INTERP = 3'd6
    } cfg_idx_t;

    // Register reset values
    localparam logic [TRIG_W-1:0] COS_RST    = 16'd16384;
    localparam logic [TRIG_W-1:0] SIN_RST    = 16'd0;
    localparam logic [DIM_W-1:0]  SRC_W_RST  = 9'd256;
    localparam logic [DIM_W-1:0]  SRC_H_RST  = 9'd256;
    localparam logic [ODIM_W-1:0] OUT_W_RST  = 10'd256;
    localparam logic [ODIM_W-1:0] OUT_H_RST  = 10'd256;
    localparam logic              INTERP_RST = 1'b1;

    // Item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_REQ  = 1'b1;

endpackage

`default_nettype wire

// ===== sv/image_rotate_inverse_warp_unit.sv =====
// Image rotation by inverse mapping with nearest or bilinear sampling.
//
// Takes one beat per clock, loads and pixel requests alike; busy never rises and
// the result strobe cannot be held off. A request gives its pixel on done once it has
// passed the capture, rotation product, source point, store access, weight, weighted
// channel and output registers; a load gives nothing and writes the frame store from
// the store access stage, so a request accepted after a load sees it.
// The rate is set by the frame store, split into four banks by row and column
// parity so that the four bilinear neighbours are read at once, one read port
// per bank. The store has no reset; pixels must be loaded before they are sampled.
`timescale 1ns / 1ps
`default_nettype none

module image_rotate_inverse_warp_unit
    import irw_pkg::*;
#(
    parameter int SRC_MAX_WIDTH  = SRC_MAX_WIDTH_DEF,
    parameter int SRC_MAX_HEIGHT = SRC_MAX_HEIGHT_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic                  mode,
    input  wire logic [COORD_W-1:0]    row,
    input  wire logic [COORD_W-1:0]    col,
    input  wire logic [CH_W-1:0]       red,
    input  wire logic [CH_W-1:0]       green,
    input  wire logic [CH_W-1:0]       blue,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // results
    output      logic                  done,
    output      logic [COORD_W-1:0]    out_row,
    output      logic [COORD_W-1:0]    out_col,
    output      logic [CH_W-1:0]       out_red,
    output      logic [CH_W-1:0]       out_green,
    output      logic [CH_W-1:0]       out_blue,
    output      logic                  inside_res
);

    localparam int CW     = $clog2(SRC_MAX_WIDTH);
    localparam int RW     = $clog2(SRC_MAX_HEIGHT);
    localparam int WW     = $clog2(SRC_MAX_WIDTH + 1);
    localparam int HW     = $clog2(SRC_MAX_HEIGHT + 1);
    localparam int XW     = ((FRAC_BITS + 10 > PROD_W + 1) ? FRAC_BITS + 10 : PROD_W + 1) + 1;
    localparam int TW     = FRAC_BITS + 10;
    localparam int BANK_W = (SRC_MAX_WIDTH + 1) / 2;
    localparam int BANK_H = (SRC_MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = BANK_W * BANK_H;
    localparam int AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // ---------------- configuration registers ----------------
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;
    logic [DIM_W-1:0]         src_w_reg, src_h_reg;
    logic [ODIM_W-1:0]        out_w_reg, out_h_reg;
    logic                     interp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= COS_RST;
            sin_reg    <= SIN_RST;
            src_w_reg  <= SRC_W_RST;
            src_h_reg  <= SRC_H_RST;
            out_w_reg  <= OUT_W_RST;
            out_h_reg  <= OUT_H_RST;
            interp_reg <= INTERP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COS:    cos_reg    <= cfg_data;
                REG_SIN:    sin_reg    <= cfg_data;
                REG_SRC_W:  src_w_reg  <= cfg_data[DIM_W-1:0];
                REG_SRC_H:  src_h_reg  <= cfg_data[DIM_W-1:0];
                REG_OUT_W:  out_w_reg  <= cfg_data[ODIM_W-1:0];
                REG_OUT_H:  out_h_reg  <= cfg_data[ODIM_W-1:0];
                REG_INTERP: interp_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Source size clamped to the store, and a zero size taken as one
    logic [WW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;

    always_comb
    begin
        if (src_w_reg == '0)
            w_clamp = WW'(1);
        else if (32'(src_w_reg) > SRC_MAX_WIDTH)
            w_clamp = WW'(SRC_MAX_WIDTH);
        else
            w_clamp = WW'(src_w_reg);
        if (src_h_reg == '0)
            h_clamp = HW'(1);
        else if (32'(src_h_reg) > SRC_MAX_HEIGHT)
            h_clamp = HW'(SRC_MAX_HEIGHT);
        else
            h_clamp = HW'(src_h_reg);
    end

    logic signed [XW-1:0] off_x, off_y, lim_x, lim_y;
    assign off_x = $signed(XW'(w_clamp >> 1) << (FRAC_BITS + 1));
    assign off_y = $signed(XW'(h_clamp >> 1) << (FRAC_BITS + 1));
    assign lim_x = $signed((XW'(w_clamp) - XW'(1)) << (FRAC_BITS + 1));
    assign lim_y = $signed((XW'(h_clamp) - XW'(1)) << (FRAC_BITS + 1));

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ---------------- stage 1: captured beat ----------------
    logic               s1_valid_reg, s1_req_reg;
    logic [COORD_W-1:0] s1_row_reg, s1_col_reg;
    logic [PIX_W-1:0]   s1_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= (mode == MODE_REQ);
            s1_row_reg <= row;
            s1_col_reg <= col;
            s1_pix_reg <= {red, green, blue};
        end
    end

    // Offsets from the output centre, in half pixels, and the four products
    logic signed [DXY_W-1:0]  dx, dy;
    assign dx = $signed({1'b0, s1_col_reg, 1'b0}) - $signed({1'b0, out_w_reg});
    assign dy = $signed({1'b0, s1_row_reg, 1'b0}) - $signed({1'b0, out_h_reg});

    // ---------------- stage 2: rotation products ----------------
    logic                      s2_valid_reg, s2_req_reg;
    logic [COORD_W-1:0]        s2_row_reg, s2_col_reg;
    logic [PIX_W-1:0]          s2_pix_reg;
    logic signed [PROD_W-1:0]  s2_xc_reg, s2_ys_reg, s2_xs_reg, s2_yc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_req_reg <= s1_req_reg;
        s2_row_reg <= s1_row_reg;
        s2_col_reg <= s1_col_reg;
        s2_pix_reg <= s1_pix_reg;
        s2_xc_reg  <= PROD_W'(dx) * PROD_W'(cos_reg);
        s2_ys_reg  <= PROD_W'(dy) * PROD_W'(sin_reg);
        s2_xs_reg  <= PROD_W'(dx) * PROD_W'(sin_reg);
        s2_yc_reg  <= PROD_W'(dy) * PROD_W'(cos_reg);
    end

    // ---------------- stage 3: source point ----------------
    logic                 s3_valid_reg, s3_req_reg;
    logic [COORD_W-1:0]   s3_row_reg, s3_col_reg;
    logic [PIX_W-1:0]     s3_pix_reg;
    logic signed [XW-1:0] s3_x_reg, s3_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_req_reg <= s2_req_reg;
        s3_row_reg <= s2_row_reg;
        s3_col_reg <= s2_col_reg;
        s3_pix_reg <= s2_pix_reg;
        s3_x_reg   <= XW'(s2_xc_reg) - XW'(s2_ys_reg) + off_x;
        s3_y_reg   <= XW'(s2_xs_reg) + XW'(s2_yc_reg) + off_y;
    end

    // Bounds, neighbour indexes and weights
    logic          in_src, wr_ok;
    logic [XW-1:0] xf, yf, xr, yr, half;
    logic [TW-1:0] tx, ty;
    logic [CW-1:0] x0_n, x1_n;
    logic [RW-1:0] y0_n, y1_n;
    logic [WT_W-1:0] wx_n, wy_n;

    assign half = XW'(1) << FRAC_BITS;

    always_comb
    begin
        in_src = !s3_x_reg[XW-1] && !s3_y_reg[XW-1] && (s3_x_reg <= lim_x) &&
                 (s3_y_reg <= lim_y);
        wr_ok  = (32'(s3_row_reg) < SRC_MAX_HEIGHT) && (32'(s3_col_reg) < SRC_MAX_WIDTH);
        xf     = XW'(s3_x_reg) >> (FRAC_BITS + 1);
        yf     = XW'(s3_y_reg) >> (FRAC_BITS + 1);
        xr     = (XW'(s3_x_reg) + half) >> (FRAC_BITS + 1);
        yr     = (XW'(s3_y_reg) + half) >> (FRAC_BITS + 1);
        tx     = (TW'(s3_x_reg[FRAC_BITS:0]) << 8) + (TW'(1) << FRAC_BITS);
        ty     = (TW'(s3_y_reg[FRAC_BITS:0]) << 8) + (TW'(1) << FRAC_BITS);
        if (!s3_req_reg)
        begin
            // load: write position
            x0_n = CW'(s3_col_reg);
            y0_n = RW'(s3_row_reg);
            x1_n = x0_n;
            y1_n = y0_n;
            wx_n = '0;
            wy_n = '0;
        end
        else if (!interp_reg)
        begin
            // nearest: all four neighbours are the same pixel
            x0_n = xr[CW-1:0];
            y0_n = yr[RW-1:0];
            x1_n = x0_n;
            y1_n = y0_n;
            wx_n = '0;
            wy_n = '0;
        end
        else
        begin
            x0_n = xf[CW-1:0];
            y0_n = yf[RW-1:0];
            x1_n = (32'(x0_n) == 32'(w_clamp) - 1) ? x0_n : x0_n + CW'(1);
            y1_n = (32'(y0_n) == 32'(h_clamp) - 1) ? y0_n : y0_n + RW'(1);
            wx_n = WT_W'(tx >> (FRAC_BITS + 1));
            wy_n = WT_W'(ty >> (FRAC_BITS + 1));
        end
    end

    // ---------------- stage 4: store access ----------------
    logic                s4_valid_reg, s4_req_reg, s4_in_reg, s4_wr_ok_reg;
    logic [COORD_W-1:0]  s4_row_reg, s4_col_reg;
    logic [PIX_W-1:0]    s4_pix_reg;
    logic [CW-1:0]       s4_x0_reg, s4_x1_reg;
    logic [RW-1:0]       s4_y0_reg, s4_y1_reg;
    logic [WT_W-1:0]     s4_wx_reg, s4_wy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_req_reg   <= s3_req_reg;
        s4_in_reg    <= in_src;
        s4_wr_ok_reg <= wr_ok;
        s4_row_reg   <= s3_row_reg;
        s4_col_reg   <= s3_col_reg;
        s4_pix_reg   <= s3_pix_reg;
        s4_x0_reg    <= x0_n;
        s4_x1_reg    <= x1_n;
        s4_y0_reg    <= y0_n;
        s4_y1_reg    <= y1_n;
        s4_wx_reg    <= wx_n;
        s4_wy_reg    <= wy_n;
    end

    logic          wr_en;
    logic [1:0]    wr_bank;
    logic [AW-1:0] bank_addr [4];
    logic [PIX_W-1:0] bank_rd [4];

    assign wr_en   = s4_valid_reg && !s4_req_reg && s4_wr_ok_reg;
    assign wr_bank = {s4_y0_reg[0], s4_x0_reg[0]};

    // Four parity banks; bank {row parity, col parity}
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(b);

        logic [PIX_W-1:0] mem [BANK_DEPTH];
        logic [PIX_W-1:0] rd_reg;
        logic [RW-1:0]    rsel;
        logic [CW-1:0]    csel;

        assign rsel = (s4_y0_reg[0] == BANK_ID[1]) ? s4_y0_reg : s4_y1_reg;
        assign csel = (s4_x0_reg[0] == BANK_ID[0]) ? s4_x0_reg : s4_x1_reg;
        assign bank_addr[b] = AW'((32'(rsel) >> 1) * BANK_W + (32'(csel) >> 1));

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == BANK_ID))
                mem[bank_addr[b]] <= s4_pix_reg;
            rd_reg <= mem[bank_addr[b]];
        end

        assign bank_rd[b] = rd_reg;
    end

    // Corner weights
    logic [WT_W-1:0] iwx, iwy;
    assign iwx = WT_W'(256) - s4_wx_reg;
    assign iwy = WT_W'(256) - s4_wy_reg;

    // ---------------- stage 5: pixels and weights ----------------
    logic                s5_valid_reg, s5_in_reg;
    logic [COORD_W-1:0]  s5_row_reg, s5_col_reg;
    logic [1:0]          s5_bank_reg [4];
    logic [WPROD_W-1:0]  s5_w_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg && s4_req_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_in_reg      <= s4_in_reg;
        s5_row_reg     <= s4_row_reg;
        s5_col_reg     <= s4_col_reg;
        s5_bank_reg[0] <= {s4_y0_reg[0], s4_x0_reg[0]};
        s5_bank_reg[1] <= {s4_y0_reg[0], s4_x1_reg[0]};
        s5_bank_reg[2] <= {s4_y1_reg[0], s4_x0_reg[0]};
        s5_bank_reg[3] <= {s4_y1_reg[0], s4_x1_reg[0]};
        s5_w_reg[0]    <= WPROD_W'(iwx) * WPROD_W'(iwy);
        s5_w_reg[1]    <= WPROD_W'(s4_wx_reg) * WPROD_W'(iwy);
        s5_w_reg[2]    <= WPROD_W'(iwx) * WPROD_W'(s4_wy_reg);
        s5_w_reg[3]    <= WPROD_W'(s4_wx_reg) * WPROD_W'(s4_wy_reg);
    end

    // ---------------- stage 6: weighted channels ----------------
    logic                s6_valid_reg, s6_in_reg;
    logic [COORD_W-1:0]  s6_row_reg, s6_col_reg;
    logic [CPROD_W-1:0]  s6_prod_reg [4][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s6_in_reg  <= s5_in_reg;
        s6_row_reg <= s5_row_reg;
        s6_col_reg <= s5_col_reg;
        for (int k = 0; k < 4; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s6_prod_reg[k][c] <=
                    CPROD_W'(bank_rd[s5_bank_reg[k]][(2 - c) * CH_W +: CH_W]) *
                    CPROD_W'(s5_w_reg[k]);
            end
        end
    end

    // Sum, round and clamp
    logic [ACC_W-1:0] acc [3];
    logic [CH_W-1:0]  chan_n [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = ACC_W'(s6_prod_reg[0][c]) + ACC_W'(s6_prod_reg[1][c]) +
                     ACC_W'(s6_prod_reg[2][c]) + ACC_W'(s6_prod_reg[3][c]) +
                     ACC_W'(32768);
            if (!s6_in_reg)
                chan_n[c] = '0;
            else if ((acc[c] >> 16) > ACC_W'(255))
                chan_n[c] = 8'd255;
            else
                chan_n[c] = acc[c][16 +: CH_W];
        end
    end

    // ---------------- output register ----------------
    logic               done_reg, inside_reg;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;
    logic [CH_W-1:0]    out_red_reg, out_green_reg, out_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        inside_reg    <= s6_in_reg;
        out_row_reg   <= s6_row_reg;
        out_col_reg   <= s6_col_reg;
        out_red_reg   <= chan_n[0];
        out_green_reg <= chan_n[1];
        out_blue_reg  <= chan_n[2];
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;

    // ---------------- assertions ----------------
    a_req_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_req_reg |-> ##6 done_reg)
        else $error("request beat lost in pipeline");

    a_load_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_req_reg |-> ##6 !done_reg)
        else $error("load beat produced a result");

    a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !inside_reg |-> (out_red_reg == '0) && (out_green_reg == '0) &&
                                    (out_blue_reg == '0))
        else $error("outside point not black");

    a_wr_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(bank_addr[wr_bank]) < BANK_DEPTH))
        else $error("store write beyond bank");

endmodule

`default_nettype wire

// ===== dv/image_rotate_inverse_warp_unit_test.sv =====
// Testbench for the image rotation inverse warp unit: frame fill, directed and random beats.
`timescale 1ns / 1ps

module image_rotate_inverse_warp_unit_test;
    import irw_pkg::*;

    localparam int SRC_W_MAX = SRC_MAX_WIDTH_DEF;
    localparam int SRC_H_MAX = SRC_MAX_HEIGHT_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam longint ONE   = longint'(1) << (FB + 1);
    localparam longint HALF  = longint'(1) << FB;
    localparam int SETTLE    = 12;
    // loaded corner of the store; every setting keeps sampling inside it
    localparam int FILL      = 24;

    typedef struct {
        logic [COORD_W-1:0] prow;
        logic [COORD_W-1:0] pcol;
        logic [CH_W-1:0]    pred;
        logic [CH_W-1:0]    pgreen;
        logic [CH_W-1:0]    pblue;
        logic               pin;
    } pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  mode = MODE_LOAD;
    logic [COORD_W-1:0]    row = '0;
    logic [COORD_W-1:0]    col = '0;
    logic [CH_W-1:0]       red = '0;
    logic [CH_W-1:0]       green = '0;
    logic [CH_W-1:0]       blue = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_COS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  done;
    logic [COORD_W-1:0]    out_row;
    logic [COORD_W-1:0]    out_col;
    logic [CH_W-1:0]       out_red;
    logic [CH_W-1:0]       out_green;
    logic [CH_W-1:0]       out_blue;
    logic                  inside_res;

    // shadow of the frame store and registers
    logic [PIX_W-1:0]  frame_img [SRC_W_MAX*SRC_H_MAX];
    logic [TRIG_W-1:0] sh_cos = COS_RST;
    logic [TRIG_W-1:0] sh_sin = SIN_RST;
    logic [DIM_W-1:0]  sh_src_w = SRC_W_RST;
    logic [DIM_W-1:0]  sh_src_h = SRC_H_RST;
    logic [ODIM_W-1:0] sh_out_w = OUT_W_RST;
    logic [ODIM_W-1:0] sh_out_h = OUT_H_RST;
    logic              sh_interp = INTERP_RST;

    pixel_t pending_pixels[$];
    int     mismatches = 0;
    int     pixels_seen = 0;
    int     inside_seen = 0;
    int     loads_sent = 0;
    int     settings_run = 0;
    bit     no_gaps = 1'b0;

    image_rotate_inverse_warp_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .row(row), .col(col), .red(red), .green(green), .blue(blue),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .out_row(out_row), .out_col(out_col), .out_red(out_red),
        .out_green(out_green), .out_blue(out_blue), .inside_res(inside_res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Inverse map one output pixel and sample the shadow frame
    function automatic pixel_t rotate_pixel(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        pixel_t p;
        longint cs, sn, w, h, dx, dy, x, y, x0, y0, x1, y1, wx, wy, acc;
        longint wt [4];
        logic [PIX_W-1:0] nb [4];
        cs = longint'($signed(sh_cos));
        sn = longint'($signed(sh_sin));
        w = (sh_src_w < 1) ? 1 : (sh_src_w > SRC_W_MAX) ? SRC_W_MAX : sh_src_w;
        h = (sh_src_h < 1) ? 1 : (sh_src_h > SRC_H_MAX) ? SRC_H_MAX : sh_src_h;
        dx = 2 * longint'(c) - longint'(sh_out_w);
        dy = 2 * longint'(r) - longint'(sh_out_h);
        x = dx * cs - dy * sn + (w / 2) * ONE;
        y = dx * sn + dy * cs + (h / 2) * ONE;
        p.prow = r;
        p.pcol = c;
        p.pred = '0;
        p.pgreen = '0;
        p.pblue = '0;
        p.pin = 1'b0;
        if (x >= 0 && y >= 0 && x <= (w - 1) * ONE && y <= (h - 1) * ONE)
        begin
            p.pin = 1'b1;
            if (!sh_interp)
            begin
                x0 = (x + HALF) >>> (FB + 1);
                y0 = (y + HALF) >>> (FB + 1);
                {p.pred, p.pgreen, p.pblue} = frame_img[y0 * SRC_W_MAX + x0];
            end
            else
            begin
                x0 = x >>> (FB + 1);
                y0 = y >>> (FB + 1);
                x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
                y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
                wx = (((x & (ONE - 1)) << 8) + HALF) >>> (FB + 1);
                wy = (((y & (ONE - 1)) << 8) + HALF) >>> (FB + 1);
                wt[0] = (256 - wx) * (256 - wy);
                wt[1] = wx * (256 - wy);
                wt[2] = (256 - wx) * wy;
                wt[3] = wx * wy;
                nb[0] = frame_img[y0 * SRC_W_MAX + x0];
                nb[1] = frame_img[y0 * SRC_W_MAX + x1];
                nb[2] = frame_img[y1 * SRC_W_MAX + x0];
                nb[3] = frame_img[y1 * SRC_W_MAX + x1];
                for (int k = 0; k < 3; k++)
                begin
                    acc = 0;
                    for (int n = 0; n < 4; n++)
                        acc += longint'(nb[n][(2 - k) * CH_W +: CH_W]) * wt[n];
                    acc = (acc + 32768) >>> 16;
                    if (acc > 255)
                        acc = 255;
                    case (k)
                        0: p.pred = acc[CH_W-1:0];
                        1: p.pgreen = acc[CH_W-1:0];
                        default: p.pblue = acc[CH_W-1:0];
                    endcase
                end
            end
        end
        return p;
    endfunction

    // One command beat; returns at the edge that accepts it, or after a gap with start low
    task automatic send_beat(logic m, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                             logic [PIX_W-1:0] rgb);
        start <= 1'b1;
        mode <= m;
        row <= r;
        col <= c;
        {red, green, blue} <= rgb;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (m == MODE_LOAD)
        begin
            loads_sent++;
            if (r < SRC_H_MAX && c < SRC_W_MAX)
                frame_img[r * SRC_W_MAX + c] = rgb;
        end
        else
            pending_pixels.push_back(rotate_pixel(r, c));
        if (!no_gaps && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_request(int r, int c);
        send_beat(MODE_REQ, r[COORD_W-1:0], c[COORD_W-1:0], PIX_W'($urandom));
    endtask

    // Registers change only with nothing in flight
    task automatic write_regs(int cs, int sn, int sw, int sh, int ow, int oh, int im);
        int vals [7];
        vals = '{cs, sn, sw, sh, ow, oh, im};
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= vals[i][CFG_DATA_W-1:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        sh_cos = cs[TRIG_W-1:0];
        sh_sin = sn[TRIG_W-1:0];
        sh_src_w = sw[DIM_W-1:0];
        sh_src_h = sh[DIM_W-1:0];
        sh_out_w = ow[ODIM_W-1:0];
        sh_out_h = oh[ODIM_W-1:0];
        sh_interp = im[0];
        settings_run++;
    endtask

    // The sampled corner of the store gets written so no unwritten entry is read
    task automatic test_frame_fill();
        for (int r = 0; r < FILL; r++)
            for (int c = 0; c < FILL; c++)
                send_beat(MODE_LOAD, r[COORD_W-1:0], c[COORD_W-1:0], PIX_W'($urandom));
        // loads past the store edge are dropped
        send_beat(MODE_LOAD, 9'd256, 9'd3, 24'hFFFFFF);
        send_beat(MODE_LOAD, 9'd7, 9'd511, 24'hFFFFFF);
        send_beat(MODE_LOAD, 9'd511, 9'd511, 24'h000000);
    endtask

    // Corners, extremes, rounding and clamps
    task automatic test_directed();
        // reset setting: identity, bilinear; far points fall outside
        send_request(0, 0);
        send_request(3, 7);
        send_request(FILL - 2, FILL - 2);
        send_request(511, 511);
        send_request(300, 0);
        write_regs(16384, 0, 256, 256, 256, 256, 0);
        send_request(0, FILL - 1);
        send_request(FILL - 1, 0);
        send_request(511, 0);
        // half-pixel offsets hit the round-half-up point in nearest
        write_regs(16384, 0, FILL, FILL, FILL - 1, FILL - 1, 0);
        send_request(10, 10);
        send_request(0, 0);
        send_request(FILL - 2, FILL - 2);
        send_request(FILL - 1, FILL - 1);
        write_regs(16384, 0, FILL, FILL, FILL - 1, FILL - 1, 1);
        send_request(10, 10);
        send_request(FILL - 2, FILL - 2);
        // source sizes above the store clamp to it
        write_regs(16384, 0, 511, 400, 256, 256, 1);
        send_request(2, 5);
        send_request(FILL - 2, 1);
        send_request(260, 4);
        send_request(4, 300);
        // full negative and positive trig, zero sizes clamp to one
        write_regs(-16384, 16384, 0, FILL, 1, 1023, 1);
        send_request(0, 0);
        send_request(100, 0);
        send_request(0, 300);
        write_regs(0, -16384, FILL, 0, 1023, 1, 0);
        send_request(0, 511);
        send_request(511, 200);
        write_regs(-32768, 32767, 1, 1, 512, 512, 1);
        send_request(256, 256);
        send_request(255, 256);
        write_regs(11585, 11585, 20, 15, 30, 30, 1);
        send_request(15, 15);
        send_request(0, 15);
    endtask

    // Random settings, each followed by a mix of requests and loads
    task automatic test_random_rotations();
        int  cs, sn, sw, sh, ow, oh, r, c;
        real ang;
        for (int ph = 0; ph < 10; ph++)
        begin
            sw = $urandom_range(1, FILL);
            sh = $urandom_range(1, FILL);
            ang = real'($urandom_range(0, 3599)) * 3.14159265358979 / 1800.0;
            cs = int'(16384.0 * $cos(ang));
            sn = int'(16384.0 * $sin(ang));
            if (ph == 9)
            begin
                cs = int'($urandom_range(0, 65535)) - 32768;
                sn = int'($urandom_range(0, 65535)) - 32768;
            end
            ow = (sw * (cs < 0 ? -cs : cs) + sh * (sn < 0 ? -sn : sn)) / 16384 + 1;
            oh = (sh * (cs < 0 ? -cs : cs) + sw * (sn < 0 ? -sn : sn)) / 16384 + 1;
            if (ow > 512) ow = 512;
            if (oh > 512) oh = 512;
            if (ph == 7)
            begin
                ow = $urandom_range(1, 1023);
                oh = $urandom_range(1, 1023);
            end
            no_gaps = (ph == 4);
            write_regs(cs, sn, sw, sh, ow, oh, $urandom_range(1));
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(9) < 2)
                begin
                    if ($urandom_range(1) == 0)
                        send_beat(MODE_LOAD, COORD_W'($urandom_range(0, FILL - 1)),
                                  COORD_W'($urandom_range(0, FILL - 1)), PIX_W'($urandom));
                    else
                        send_beat(MODE_LOAD, COORD_W'($urandom_range(0, 511)),
                                  COORD_W'($urandom_range(0, 511)), PIX_W'($urandom));
                end
                else
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        r = $urandom_range(0, 511);
                        c = $urandom_range(0, 511);
                    end
                    else
                    begin
                        r = $urandom_range(0, (oh > 512 ? 512 : oh) - 1);
                        c = $urandom_range(0, (ow > 512 ? 512 : ow) - 1);
                    end
                    send_request(r, c);
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // Compare each result beat with the oldest predicted pixel
    always @(negedge clk)
    begin
        pixel_t e;
        if (rst_n && done)
        begin
            pixels_seen++;
            if (inside_res)
                inside_seen++;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel beat row %0d col %0d",
                             $realtime, out_row, out_col);
            end
            else
            begin
                e = pending_pixels.pop_front();
                if (out_row !== e.prow || out_col !== e.pcol || out_red !== e.pred ||
                    out_green !== e.pgreen || out_blue !== e.pblue || inside_res !== e.pin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: pixel mismatch exp %0d,%0d rgb %h %h %h in %b;",
                                  " got %0d,%0d rgb %h %h %h in %b"},
                                 $realtime, e.prow, e.pcol, e.pred, e.pgreen, e.pblue, e.pin,
                                 out_row, out_col, out_red, out_green, out_blue, inside_res);
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_frame_fill();
        test_directed();
        test_random_rotations();
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d loads and %0d pixels (%0d inside the source) over %0d settings.",
                 loads_sent, pixels_seen, inside_seen, settings_run);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("image_rotate_inverse_warp_unit verification clean");
        else
            $display("image_rotate_inverse_warp_unit verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d pixels outstanding", pending_pixels.size());
        $display("image_rotate_inverse_warp_unit verification failed");
        $finish;
    end

endmodule
